[hw/rtl/fixed_capacity_set_store_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fixed capacity set store
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef FIXED_CAPACITY_SET_STORE_ASSERT_SVH
`define FIXED_CAPACITY_SET_STORE_ASSERT_SVH

// Property checked at every clock edge outside of reset.
`define FCSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fixed_capacity_set_store: assertion failed");

// Property checked at every clock edge, reset included.
`define FCSS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("fixed_capacity_set_store: assertion failed");

`endif

[hw/rtl/fcss_pkg.sv]
// ----------------------------------------------------------------------------
// fcss_pkg
// Types and constants shared by the fixed capacity set store modules.
// ----------------------------------------------------------------------------
package fcss_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Operation codes carried on the request channel.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
    logic scan_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic scan_last;
  } dp_sts_t;

endpackage

[hw/rtl/fcss_if.sv]
// ----------------------------------------------------------------------------
// fcss request and response channels
// Valid/ready channel interfaces for set operations and their results.
// ----------------------------------------------------------------------------
interface fcss_req_if;
  logic                              valid;
  logic                              ready;
  logic [fcss_pkg::OP_W-1:0]         operation;
  logic signed [fcss_pkg::DATA_W-1:0] element;

  modport source (output valid, operation, element, input ready);
  modport sink (input valid, operation, element, output ready);
endinterface

interface fcss_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               success;
  logic [fcss_pkg::COUNT_W-1:0]       count;
  logic                               is_empty;
  logic signed [fcss_pkg::DATA_W-1:0] min_value;
  logic signed [fcss_pkg::DATA_W-1:0] max_value;
  logic                               extremes_valid;

  modport source (output valid, success, count, is_empty, min_value, max_value,
                  extremes_valid, input ready);
  modport sink (input valid, success, count, is_empty, min_value, max_value,
                extremes_valid, output ready);
endinterface

[hw/rtl/fcss_datapath.sv]
// ----------------------------------------------------------------------------
// fcss_datapath
// Cell array with parallel match, shift-down removal, extreme scan and the
// result register.
// ----------------------------------------------------------------------------
module fcss_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fcss_pkg::dp_cmd_t                  cmd_i,
  output fcss_pkg::dp_sts_t                  sts_o,
  input  logic [fcss_pkg::OP_W-1:0]          operation_i,
  input  logic signed [fcss_pkg::DATA_W-1:0] element_i,
  output logic                               success_o,
  output logic [fcss_pkg::COUNT_W-1:0]       count_o,
  output logic                               is_empty_o,
  output logic signed [fcss_pkg::DATA_W-1:0] min_value_o,
  output logic signed [fcss_pkg::DATA_W-1:0] max_value_o,
  output logic                               extremes_valid_o
);
  import fcss_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] elem_q;
  logic signed [DATA_W-1:0] cells_q [CAPACITY];
  logic [CNT_W-1:0]         occ_q, occ_d;
  logic                     ok_q;
  logic [IDX_W-1:0]         scan_q;
  logic signed [DATA_W-1:0] lo_q, hi_q;
  logic signed [DATA_W-1:0] scan_val;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] after_hit;
  logic                hit, full, do_insert, do_remove, empty;

  // Parallel compare against every occupied cell. Values are distinct, so at
  // most one cell matches; after_hit marks the match and every cell above it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_match
    assign match[i] = (CNT_W'(i) < occ_q) && (cells_q[i] == elem_q);
    if (i == 0) begin : g_first
      assign after_hit[i] = match[i];
    end else begin : g_rest
      assign after_hit[i] = after_hit[i-1] | match[i];
    end
  end

  assign hit       = |match;
  assign full      = (occ_q == CNT_W'(CAPACITY));
  assign empty     = (occ_q == '0);
  assign do_insert = (op_q == OP_INSERT) && !full && !hit;
  assign do_remove = (op_q == OP_REMOVE) && hit;

  always_comb begin
    occ_d = occ_q;
    if (do_insert) begin
      occ_d = occ_q + CNT_W'(1);
    end else if (do_remove) begin
      occ_d = occ_q - CNT_W'(1);
    end
  end

  // Each cell either takes an appended value or the value of its upper
  // neighbor when a removal closes the gap.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.update) begin
        if (do_insert && (CNT_W'(i) == occ_q)) begin
          cells_q[i] <= elem_q;
        end else if (do_remove && after_hit[i]) begin
          if (i < CAPACITY - 1) begin
            cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      ok_q   <= 1'b0;
      scan_q <= '0;
    end else begin
      if (cmd_i.update) begin
        occ_q <= occ_d;
        ok_q  <= do_insert || do_remove || ((op_q == OP_QUERY) && hit);
      end
      if (cmd_i.capture) begin
        scan_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + IDX_W'(1);
      end
    end
  end

  assign scan_val = cells_q[scan_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      elem_q <= element_i;
    end
    if (cmd_i.scan_step) begin
      if (scan_q == '0) begin
        lo_q <= scan_val;
        hi_q <= scan_val;
      end else begin
        if (scan_val < lo_q) begin
          lo_q <= scan_val;
        end
        if (scan_val > hi_q) begin
          hi_q <= scan_val;
        end
      end
    end
    if (cmd_i.load_out) begin
      success_o        <= ok_q;
      count_o          <= COUNT_W'(occ_q);
      is_empty_o       <= empty;
      min_value_o      <= empty ? '0 : lo_q;
      max_value_o      <= empty ? '0 : hi_q;
      extremes_valid_o <= !empty;
    end
  end

  assign sts_o.empty     = empty;
  assign sts_o.scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == occ_q);

  `include "fixed_capacity_set_store_assert.svh"

  `FCSS_ASSERT(a_occ_bounded, occ_q <= CNT_W'(CAPACITY))
  `FCSS_ASSERT(a_occ_only_on_update, !cmd_i.update |=> $stable(occ_q))
  `FCSS_ASSERT(a_query_keeps_occ, (cmd_i.update && (op_q == OP_QUERY)) |=> $stable(occ_q))
  `FCSS_ASSERT(a_single_match, $onehot0(match))

endmodule

[hw/rtl/fcss_ctrl.sv]
// ----------------------------------------------------------------------------
// fcss_ctrl
// Sequencer for capture, update, extreme scan and result hand-off.
// ----------------------------------------------------------------------------
module fcss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fcss_pkg::dp_cmd_t cmd_o,
  input  fcss_pkg::dp_sts_t sts_i
);
  import fcss_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.empty) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_last) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        // The result register takes the new result once the previous one is
        // gone or leaves in this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/fixed_capacity_set_store.sv]
// ----------------------------------------------------------------------------
// fixed_capacity_set_store
// Set of distinct signed 32-bit values kept in insertion order, with insert,
// remove and membership query requests and a result per request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_i     in         operation (insert, remove, query), element
//   rsp_o     out        success, count, is_empty, min_value, max_value,
//                        extremes_valid
//
// A request runs from acceptance through an update state, for the parallel
// match and the append or shift-down, and a scan state for the minimum and
// maximum, one element per cycle over the elements stored after the
// operation (a single pass when the set is empty), to an output state that
// loads the result into the response register. The request channel is ready
// again in the cycle after the load, so a new request is taken only once the
// previous one has been loaded. Unless the response stalls, the scan over
// the cells sets the request rate.
// Reset clears the count and the control state; cell contents are left as is,
// since only cells below the count are ever read.
// A new request is accepted while the previous result still waits in the
// response register; a stalled response holds the controller in its output
// state until the register frees up; the next result waits in the datapath.
//
module fixed_capacity_set_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcss_req_if.sink   req_i,
  fcss_rsp_if.source rsp_o
);
  import fcss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences each request; it sees the datapath only through
  // the command and status structs.
  fcss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the cells, the count, the scan and the result register.
  fcss_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (req_i.operation),
    .element_i        (req_i.element),
    .success_o        (rsp_o.success),
    .count_o          (rsp_o.count),
    .is_empty_o       (rsp_o.is_empty),
    .min_value_o      (rsp_o.min_value),
    .max_value_o      (rsp_o.max_value),
    .extremes_valid_o (rsp_o.extremes_valid)
  );

endmodule
